@@ src/vit_pkg.sv @@
`timescale 1ns / 1ps
package vit_pkg;

  // generator register file
  localparam int GEN_W     = 7;
  localparam int NUM_GEN   = 4;
  localparam int CFG_IDX_W = 8;

  // stream payloads
  localparam int WORD_W    = 4;
  localparam int TDATA_W   = 8;

  // hamming distance of up to four code bits
  localparam int BM_W      = 3;

  typedef logic [GEN_W-1:0] gen_t;
  typedef gen_t [NUM_GEN-1:0] gen_vec_t;

  localparam gen_t GEN0_RST = 7'd121;
  localparam gen_t GEN1_RST = 7'd91;
  localparam gen_t GEN2_RST = 7'd0;
  localparam gen_t GEN3_RST = 7'd0;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GEN_0 = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GEN_1 = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GEN_2 = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GEN_3 = 8'd3;

endpackage

@@ src/vit_ram.sv @@
`timescale 1ns / 1ps
module vit_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write, one registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ src/vit_bmu.sv @@
`timescale 1ns / 1ps
module vit_bmu #(
  parameter int K  = 7,
  parameter int CB = 2
) (
  input  logic [K-2:0]              from_state,
  input  logic                      info_bit,
  input  logic [vit_pkg::WORD_W-1:0] rx_word,
  input  vit_pkg::gen_vec_t         gens,
  output logic [vit_pkg::BM_W-1:0]  distance
);
  import vit_pkg::*;

  logic [K-1:0]       sr;
  logic [GEN_W+K-1:0] gx;
  logic               par;

  // encode the branch and count mismatches, first code bit against the top bit
  always_comb begin
    distance = '0;
    sr       = {from_state, info_bit};
    gx       = '0;
    par      = 1'b0;
    for (int j = 0; j < CB; j++) begin
      gx       = {{K{1'b0}}, gens[j]};
      par      = ^(sr & gx[K-1:0]);
      distance = distance + BM_W'(par ^ rx_word[CB-1-j]);
    end
  end

endmodule

@@ src/viterbi_hard_decision_decoder.sv @@
`timescale 1ns / 1ps
// Hard-decision Viterbi decoder, one decoded bit per received code word. Each word is
// processed alone and in_tready stays low until its bit is handed to the output register.
// Each word runs add-compare-select state by state (ACS_A, ACS_B, ACS_C) through the single
// branch-metric unit and the metric memory's one read port, then normalisation (NORM_A,
// NORM_B), a scan for candidates, and a traceback from every state that shares the least
// metric. Window memories are not swept after reset: a fill count makes unwritten columns
// read as zero, so the block is ready at once. Generators are written on the cfg port; the
// user must write them only while the block is idle, as the block itself does not enforce it.
module viterbi_hard_decision_decoder #(
  parameter int CONSTRAINT_LENGTH = 7,
  parameter int CODED_BITS        = 2,
  parameter int TRACEBACK_DEPTH   = 35,
  parameter int METRIC_WIDTH      = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // received word stream
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [vit_pkg::TDATA_W-1:0]    in_tdata,   // [3:0] received_word
  // decoded bit stream
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [vit_pkg::TDATA_W-1:0]    out_tdata,  // [0] decoded_bit
  // register writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [vit_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [vit_pkg::GEN_W-1:0]      cfg_data
);
  import vit_pkg::*;

  localparam int S      = CONSTRAINT_LENGTH - 1;
  localparam int NS     = 1 << S;
  localparam int TD     = TRACEBACK_DEPTH;
  localparam int MW     = METRIC_WIDTH;
  localparam int SLOT_W = $clog2(TD);
  localparam int FILL_W = $clog2(TD + 1);
  localparam int AW     = $clog2(TD * NS);
  localparam int RAW_W  = MW + 1;
  localparam int SUM_W  = MW + SLOT_W;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_ACS_A  = 4'd1;
  localparam logic [3:0] ST_ACS_B  = 4'd2;
  localparam logic [3:0] ST_ACS_C  = 4'd3;
  localparam logic [3:0] ST_NORM_A = 4'd4;
  localparam logic [3:0] ST_NORM_B = 4'd5;
  localparam logic [3:0] ST_SCAN   = 4'd6;
  localparam logic [3:0] ST_TB     = 4'd7;
  localparam logic [3:0] ST_OUT    = 4'd8;

  function automatic logic [AW-1:0] mk_addr(input logic [SLOT_W-1:0] sl,
                                            input logic [S-1:0] st);
    logic [SLOT_W+S-1:0] c;
    c = {sl, st};
    return c[AW-1:0];
  endfunction

  function automatic logic [SLOT_W-1:0] slot_dec(input logic [SLOT_W-1:0] sl);
    return (sl == '0) ? SLOT_W'(TD - 1) : sl - SLOT_W'(1);
  endfunction

  function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] sl);
    return (sl == SLOT_W'(TD - 1)) ? '0 : sl + SLOT_W'(1);
  endfunction

  logic [3:0]        state_r, state_nxt;
  gen_vec_t          gen_r;
  logic [WORD_W-1:0] rx_r, rx_nxt;
  logic [SLOT_W-1:0] wp_r, wp_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [S-1:0]      d_r, d_nxt;
  logic [RAW_W-1:0]  cand0_r, cand0_nxt;
  logic [RAW_W-1:0]  least_r, least_nxt;
  logic [NS-1:0]     cand_r, cand_nxt;
  logic [S-1:0]      cur_r, cur_nxt;
  logic [SLOT_W-1:0] age_r, age_nxt;
  logic [SLOT_W-1:0] tslot_r, tslot_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [SUM_W-1:0]  best_sum_r, best_sum_nxt;
  logic              found_r, found_nxt;
  logic              trace_bit_r, trace_bit_nxt;
  logic              best_bit_r, best_bit_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_bit_r, out_bit_nxt;

  // memory ports
  logic            m_we, m_re, s_we, s_re, r_we, r_re;
  logic [AW-1:0]   m_waddr, m_raddr, s_waddr, s_raddr;
  logic [MW-1:0]   m_wdata, m_rd;
  logic [S-1:0]    s_wdata, s_rd;
  logic [S-1:0]    r_waddr, r_raddr;
  logic [RAW_W-1:0] r_wdata, r_rd;

  // branch metric unit
  logic [S-1:0]    from0, from1, bm_from;
  logic [BM_W-1:0] bm_dist;

  logic [RAW_W-1:0] m_ext, cand_cur, raw_v, norm_v;
  logic             prev_valid, age_valid, sel1;
  logic [SUM_W-1:0] sum_new;
  logic [S-1:0]     surv_v;
  logic [SLOT_W-1:0] ns_slot;

  assign from0   = {1'b0, d_r[S-1:1]};
  assign from1   = {1'b1, d_r[S-1:1]};
  assign bm_from = (state_r == ST_ACS_C) ? from1 : from0;

  vit_bmu #(.K(CONSTRAINT_LENGTH), .CB(CODED_BITS)) u_bmu (
    .from_state (bm_from),
    .info_bit   (d_r[0]),
    .rx_word    (rx_r),
    .gens       (gen_r),
    .distance   (bm_dist)
  );

  vit_ram #(.WIDTH(MW), .DEPTH(TD * NS)) u_metric_ram (
    .clk(clk), .wr_en(m_we), .wr_addr(m_waddr), .wr_data(m_wdata),
    .rd_en(m_re), .rd_addr(m_raddr), .rd_data(m_rd)
  );

  vit_ram #(.WIDTH(S), .DEPTH(TD * NS)) u_surv_ram (
    .clk(clk), .wr_en(s_we), .wr_addr(s_waddr), .wr_data(s_wdata),
    .rd_en(s_re), .rd_addr(s_raddr), .rd_data(s_rd)
  );

  vit_ram #(.WIDTH(RAW_W), .DEPTH(NS)) u_raw_ram (
    .clk(clk), .wr_en(r_we), .wr_addr(r_waddr), .wr_data(r_wdata),
    .rd_en(r_re), .rd_addr(r_raddr), .rd_data(r_rd)
  );

  // register writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gen_r[0] <= GEN0_RST;
      gen_r[1] <= GEN1_RST;
      gen_r[2] <= GEN2_RST;
      gen_r[3] <= GEN3_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_GEN_0: gen_r[0] <= cfg_data;
        REG_GEN_1: gen_r[1] <= cfg_data;
        REG_GEN_2: gen_r[2] <= cfg_data;
        REG_GEN_3: gen_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // shared datapath terms
  assign prev_valid = fill_r > FILL_W'(1);
  assign age_valid  = FILL_W'(age_r) < fill_r;
  assign m_ext      = prev_valid ? {1'b0, m_rd} : '0;
  assign cand_cur   = m_ext + RAW_W'(bm_dist);
  assign sel1       = cand_cur < cand0_r;
  assign raw_v      = sel1 ? cand_cur : cand0_r;
  assign norm_v     = r_rd - least_r;
  assign sum_new    = sum_r + (age_valid ? SUM_W'(m_rd) : '0);
  assign surv_v     = age_valid ? s_rd : '0;
  assign ns_slot    = slot_dec(tslot_r);

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(TDATA_W-1){1'b0}}, out_bit_r};

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    rx_nxt        = rx_r;
    wp_nxt        = wp_r;
    fill_nxt      = fill_r;
    d_nxt         = d_r;
    cand0_nxt     = cand0_r;
    least_nxt     = least_r;
    cand_nxt      = cand_r;
    cur_nxt       = cur_r;
    age_nxt       = age_r;
    tslot_nxt     = tslot_r;
    sum_nxt       = sum_r;
    best_sum_nxt  = best_sum_r;
    found_nxt     = found_r;
    trace_bit_nxt = trace_bit_r;
    best_bit_nxt  = best_bit_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_bit_nxt   = out_bit_r;
    m_we = 1'b0; m_waddr = mk_addr(wp_r, d_r); m_wdata = '0;
    m_re = 1'b0; m_raddr = mk_addr(slot_dec(wp_r), from0);
    s_we = 1'b0; s_waddr = mk_addr(wp_r, d_r); s_wdata = sel1 ? from1 : from0;
    s_re = 1'b0; s_raddr = mk_addr(wp_r, d_r);
    r_we = 1'b0; r_waddr = d_r; r_wdata = raw_v;
    r_re = 1'b0; r_raddr = d_r;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          rx_nxt    = in_tdata[WORD_W-1:0];
          wp_nxt    = slot_inc(wp_r);
          fill_nxt  = (fill_r == FILL_W'(TD)) ? fill_r : fill_r + FILL_W'(1);
          d_nxt     = '0;
          state_nxt = ST_ACS_A;
        end
      end
      ST_ACS_A: begin
        m_re      = 1'b1;
        state_nxt = ST_ACS_B;
      end
      ST_ACS_B: begin
        cand0_nxt = cand_cur;
        m_re      = 1'b1;
        m_raddr   = mk_addr(slot_dec(wp_r), from1);
        state_nxt = ST_ACS_C;
      end
      ST_ACS_C: begin
        // lower source keeps a tie
        r_we = 1'b1;
        s_we = 1'b1;
        if (d_r == '0 || raw_v < least_r) begin
          least_nxt = raw_v;
        end
        d_nxt = d_r + S'(1);
        state_nxt = (d_r == S'(NS - 1)) ? ST_NORM_A : ST_ACS_A;
      end
      ST_NORM_A: begin
        r_re      = 1'b1;
        state_nxt = ST_NORM_B;
      end
      ST_NORM_B: begin
        m_we          = 1'b1;
        m_wdata       = norm_v[RAW_W-1] ? {MW{1'b1}} : norm_v[MW-1:0];
        cand_nxt[d_r] = (norm_v == '0);
        d_nxt         = d_r + S'(1);
        if (d_r == S'(NS - 1)) begin
          found_nxt = 1'b0;
          state_nxt = ST_SCAN;
        end else begin
          state_nxt = ST_NORM_A;
        end
      end
      ST_SCAN: begin
        if (cand_r[d_r]) begin
          m_re      = 1'b1;
          m_raddr   = mk_addr(wp_r, d_r);
          s_re      = 1'b1;
          cur_nxt   = d_r;
          tslot_nxt = wp_r;
          age_nxt   = '0;
          sum_nxt   = '0;
          state_nxt = ST_TB;
        end else if (d_r == S'(NS - 1)) begin
          state_nxt = ST_OUT;
        end else begin
          d_nxt = d_r + S'(1);
        end
      end
      ST_TB: begin
        // one trellis step per cycle
        if (age_r == SLOT_W'(TD - 2)) begin
          trace_bit_nxt = cur_r[0];
        end
        if (age_r == SLOT_W'(TD - 1)) begin
          if (!found_r || sum_new < best_sum_r) begin
            best_sum_nxt = sum_new;
            best_bit_nxt = trace_bit_r;
          end
          found_nxt = 1'b1;
          if (d_r == S'(NS - 1)) begin
            state_nxt = ST_OUT;
          end else begin
            d_nxt     = d_r + S'(1);
            state_nxt = ST_SCAN;
          end
        end else begin
          m_re      = 1'b1;
          s_re      = 1'b1;
          m_raddr   = mk_addr(ns_slot, surv_v);
          s_raddr   = mk_addr(ns_slot, surv_v);
          cur_nxt   = surv_v;
          tslot_nxt = ns_slot;
          age_nxt   = age_r + SLOT_W'(1);
          sum_nxt   = sum_new;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_bit_nxt   = best_bit_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wp_r        <= '0;
      fill_r      <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      fill_r      <= fill_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    rx_r        <= rx_nxt;
    d_r         <= d_nxt;
    cand0_r     <= cand0_nxt;
    least_r     <= least_nxt;
    cand_r      <= cand_nxt;
    cur_r       <= cur_nxt;
    age_r       <= age_nxt;
    tslot_r     <= tslot_nxt;
    sum_r       <= sum_nxt;
    best_sum_r  <= best_sum_nxt;
    trace_bit_r <= trace_bit_nxt;
    best_bit_r  <= best_bit_nxt;
    out_bit_r   <= out_bit_nxt;
  end

  // checks
  a_accept_starts_acs: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == ST_ACS_A)
    else $error("accepted word did not start add-compare-select");

  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(TD))
    else $error("fill count beyond window depth");

  a_out_has_winner: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_OUT |-> found_r)
    else $error("output stage reached without a traced candidate");

  a_trace_from_candidate: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_TB && age_r == '0 |-> cand_r[cur_r] && cur_r == d_r)
    else $error("traceback started from a state without least metric");

endmodule

@@ dv/tb_viterbi_hard_decision_decoder.sv @@
`timescale 1ns / 1ps
module tb_viterbi_hard_decision_decoder;
  import vit_pkg::*;

  localparam int K       = 7;
  localparam int NCODE   = 2;
  localparam int DEPTH   = 35;
  localparam int MW      = 16;
  localparam int NST     = 1 << (K - 1);
  localparam int SMSK    = NST - 1;
  localparam int RMSK    = (1 << K) - 1;
  localparam longint MMAX = (64'd1 << MW) - 1;
  localparam int STALL_LIMIT = 20000;
  localparam int LONG_HOLD   = 3000;
  // an index past the register file, writes to it are dropped
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 8'd200;

  // decoder model and store of expected decoded bits
  class decode_scoreboard;
    gen_t        gens [NUM_GEN];
    int unsigned path_metric [NST][DEPTH];
    int unsigned survivor [NST][DEPTH];
    bit          bit_queue [$];
    int          errors;

    function void clear();
      gens[0] = GEN0_RST; gens[1] = GEN1_RST; gens[2] = GEN2_RST; gens[3] = GEN3_RST;
      foreach (path_metric[s, c]) begin
        path_metric[s][c] = 0;
        survivor[s][c] = 0;
      end
      bit_queue.delete();
      errors = 0;
    endfunction

    function void write_gen(logic [CFG_IDX_W-1:0] idx, gen_t val);
      if (idx < NUM_GEN) gens[idx] = val;
    endfunction

    function int unsigned branch_word(int unsigned s, int unsigned b);
      int unsigned sr;
      int unsigned w;
      sr = ((s << 1) | b) & RMSK;
      w = 0;
      for (int j = 0; j < NCODE; j++) w = (w << 1) | (^(sr & gens[j]));
      return w;
    endfunction

    // one trellis step, queues the decoded bit it yields
    function void note_word(logic [WORD_W-1:0] word);
      int unsigned rx, from, cur, best_state;
      longint      cand, least, sum, best_sum;
      longint      raw [NST];
      int unsigned src [NST];
      int unsigned minm;
      bit          found;
      rx = word & ((1 << NCODE) - 1);
      for (int s = 0; s < NST; s++)
        for (int c = 0; c < DEPTH - 1; c++) begin
          path_metric[s][c] = path_metric[s][c+1];
          survivor[s][c] = survivor[s][c+1];
        end
      // add-compare-select, lower source wins ties
      for (int d = 0; d < NST; d++)
        for (int x = 0; x < 2; x++) begin
          from = ((d >> 1) | (x << (K - 2))) & SMSK;
          cand = path_metric[from][DEPTH-2] + $countones(branch_word(from, d & 1) ^ rx);
          if (x == 0 || cand < raw[d]) begin
            raw[d] = cand;
            src[d] = from;
          end
        end
      // normalise and saturate
      least = raw[0];
      for (int d = 1; d < NST; d++) if (raw[d] < least) least = raw[d];
      for (int d = 0; d < NST; d++) begin
        cand = raw[d] - least;
        if (cand > MMAX) cand = MMAX;
        path_metric[d][DEPTH-1] = cand;
        survivor[d][DEPTH-1] = src[d];
      end
      minm = path_metric[0][DEPTH-1];
      for (int d = 1; d < NST; d++)
        if (path_metric[d][DEPTH-1] < minm) minm = path_metric[d][DEPTH-1];
      // tied final states broken by summed window metrics along the path
      found = 0;
      best_sum = 0;
      best_state = 0;
      for (int d = 0; d < NST; d++) begin
        if (path_metric[d][DEPTH-1] != minm) continue;
        sum = path_metric[d][DEPTH-1];
        cur = d;
        for (int t = DEPTH - 1; t > 0; t--) begin
          cur = survivor[cur][t] & SMSK;
          sum += path_metric[cur][t-1];
        end
        if (!found || sum < best_sum) begin
          found = 1;
          best_sum = sum;
          best_state = d;
        end
      end
      cur = best_state;
      for (int t = DEPTH - 1; t > 1; t--) cur = survivor[cur][t] & SMSK;
      bit_queue.push_back(cur[0]);
    endfunction

    function void check_bit(logic [TDATA_W-1:0] data);
      bit exp_bit;
      if (bit_queue.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected decoded bit %0d", data[0]);
        return;
      end
      exp_bit = bit_queue.pop_front();
      if (data[0] !== exp_bit) begin
        errors++;
        if (errors <= 10) $display("decoded_bit mismatch: expected %0d actual %0d",
                                   exp_bit, data[0]);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [TDATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [TDATA_W-1:0] out_tdata;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [GEN_W-1:0] cfg_data = '0;

  decode_scoreboard sb = new();
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_req = 0;
  int idle_cycles = 0;
  int unsigned enc_state = 0;

  viterbi_hard_decision_decoder dut (.*);

  initial forever #4 clk = ~clk;

  // receiver: random stalls, plus long hold-offs on request
  initial begin
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // result check
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_bit(out_tdata);
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic send_word(logic [WORD_W-1:0] word);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {{(TDATA_W-WORD_W){1'b0}}, word};
    do @(posedge clk); while (!in_tready);
    sb.note_word(word);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.bit_queue.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, gen_t val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.write_gen(idx, val);
  endtask

  task automatic set_gens(gen_t g0, gen_t g1, gen_t g2, gen_t g3);
    write_reg(REG_GEN_0, g0);
    write_reg(REG_GEN_1, g1);
    write_reg(REG_GEN_2, g2);
    write_reg(REG_GEN_3, g3);
    enc_state = 0;
  endtask

  // mostly encoded streams with sparse bit errors, the rest raw noise
  task automatic send_random(int count);
    int unsigned b, w;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 75) begin
        b = $urandom_range(1);
        w = sb.branch_word(enc_state, b);
        enc_state = ((enc_state << 1) | b) & SMSK;
        if ($urandom_range(99) < 8) w ^= (1 << $urandom_range(NCODE - 1));
        w |= $urandom_range(3) << NCODE;
        send_word(w);
      end else begin
        send_word($urandom_range(15));
      end
    end
  endtask

  initial begin
    sb.clear();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: field extremes and ignored upper bits at reset generators
    send_word(4'h0); send_word(4'hF); send_word(4'h3); send_word(4'hC);
    send_word(4'h1); send_word(4'h2); send_word(4'hE); send_word(4'hD);
    // extreme generators and an unmapped index
    drain();
    set_gens(7'd127, 7'd0, 7'd127, 7'd127);
    write_reg(REG_UNMAPPED, 7'd5);
    send_word(4'h3); send_word(4'h0); send_word(4'h2); send_word(4'h1);
    // all-zero generators give fully tied metrics
    drain();
    set_gens(7'd0, 7'd0, 7'd0, 7'd0);
    send_word(4'h3); send_word(4'h3); send_word(4'h0); send_word(4'h2);
    send_word(4'hB);

    // receiver idles more than sender
    drain();
    set_gens(7'd121, 7'd91, 7'd33, 7'd64);
    tx_idle_pct = 23; rx_idle_pct = 49;
    send_random(170);

    // sender idles more than receiver
    drain();
    set_gens(7'd5, 7'd7, 7'd0, 7'd0);
    tx_idle_pct = 49; rx_idle_pct = 23;
    send_random(170);

    // no idling, one long receiver hold-off to back up the input
    drain();
    set_gens(7'd109, 7'd79, 7'd0, 7'd0);
    tx_idle_pct = 0; rx_idle_pct = 0;
    hold_req = hold_req + 1;
    send_random(170);

    drain();
    repeat (100) @(posedge clk);
    if (sb.errors == 0 && sb.bit_queue.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
